// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty bodies for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RASI_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define RASI_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) pre |=> post) \
    else $error("assertion failed");
`else
`define RASI_ASSERT(lbl, clk, rstn, prop)
`define RASI_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

// ===== rtl/rasi_pkg.sv =====
// ---------------------------------------------------------------------------
// rasi_pkg
// Widths, register indexes and slab merge logic of the ray/box unit.
// ---------------------------------------------------------------------------
package rasi_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int MAG_W     = COORD_W + 1;
  localparam int Q_W       = COORD_W - 1;
  localparam int NUM_W     = MAG_W + FRAC_W;
  localparam int DIV_STEPS = Q_W;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  // edges from the ray transfer to the result transfer
  localparam int PIPE_LAT  = DIV_LAT + 4;
  localparam int IDX_W     = 3;

  localparam logic [IDX_W-1:0] REG_MIN_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAX_Z = 3'd5;

  typedef struct packed {
    logic                      have;
    logic                      fail;
    logic signed [COORD_W-1:0] tmin;
    logic signed [COORD_W-1:0] tmax;
  } slab_t;

  typedef struct packed {
    logic dzero;
    logic in_slab;
  } axis_flags_t;

  function automatic slab_t slab_merge(slab_t s, logic signed [COORD_W-1:0] an,
                                       logic signed [COORD_W-1:0] af,
                                       axis_flags_t f);
    slab_t r;
    r = s;
    if (!s.fail) begin
      if (f.dzero) begin
        if (!f.in_slab) r.fail = 1'b1;
      end else if (!s.have) begin
        r.have = 1'b1;
        r.tmin = an;
        r.tmax = af;
      end else if ((s.tmin > af) || (an > s.tmax)) begin
        r.fail = 1'b1;
      end else begin
        if (an > s.tmin) r.tmin = an;
        if (af < s.tmax) r.tmax = af;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/ray_aabb_slab_intersect_unit.sv =====
// ---------------------------------------------------------------------------
// ray_aabb_slab_intersect_unit
// Ray versus axis-aligned box slab test in signed Q16.16.
// ---------------------------------------------------------------------------
// Usage:
//   The box corners are six registers written through the cfg channel
//   (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i); ready is always high
//   and indexes beyond the list are dropped. Write them only while idle.
//   A ray transfers when start is high and busy is low. busy never rises:
//   a new ray can enter on every cycle.
//   The result (hit_o, fraction_o) appears for one cycle with valid_o high,
//   after the plane-difference, magnitude, divider, merge and output registers;
//   it transfers at the next edge. Throughput is one ray per cycle, set by the six
//   dividers, each a chain of 31 compare/subtract stages.
//   The receiver cannot stall, so results are never held back.
//   Reset clears the box to zero and empties the pipeline; rays in flight
//   are dropped.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ray_aabb_slab_intersect_unit (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [rasi_pkg::IDX_W-1:0]                 cfg_index_i,
  input  logic [rasi_pkg::COORD_W-1:0]               cfg_data_i,
  input  logic                                       start,
  output logic                                       busy,
  input  logic signed [rasi_pkg::COORD_W-1:0]        origin_x_i,
  input  logic signed [rasi_pkg::COORD_W-1:0]        origin_y_i,
  input  logic signed [rasi_pkg::COORD_W-1:0]        origin_z_i,
  input  logic signed [rasi_pkg::COORD_W-1:0]        dir_x_i,
  input  logic signed [rasi_pkg::COORD_W-1:0]        dir_y_i,
  input  logic signed [rasi_pkg::COORD_W-1:0]        dir_z_i,
  output logic                                       valid_o,
  output logic                                       hit_o,
  output logic [rasi_pkg::COORD_W-2:0]               fraction_o
);

  localparam int CW = rasi_pkg::COORD_W;
  localparam int MW = rasi_pkg::MAG_W;
  localparam int DL = rasi_pkg::DIV_LAT;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  // box registers
  logic signed [CW-1:0] box_min_q [3];
  logic signed [CW-1:0] box_max_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        box_min_q[a] <= '0;
        box_max_q[a] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        rasi_pkg::REG_MIN_X: box_min_q[0] <= cfg_data_i;
        rasi_pkg::REG_MIN_Y: box_min_q[1] <= cfg_data_i;
        rasi_pkg::REG_MIN_Z: box_min_q[2] <= cfg_data_i;
        rasi_pkg::REG_MAX_X: box_max_q[0] <= cfg_data_i;
        rasi_pkg::REG_MAX_Y: box_max_q[1] <= cfg_data_i;
        rasi_pkg::REG_MAX_Z: box_max_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [CW-1:0] org [3];
  logic signed [CW-1:0] dir [3];

  always_comb begin
    org[0] = origin_x_i; org[1] = origin_y_i; org[2] = origin_z_i;
    dir[0] = dir_x_i;    dir[1] = dir_y_i;    dir[2] = dir_z_i;
  end

  // stage 0: plane differences
  logic                 in_xfer;
  logic                 v0_q, v1_q;
  logic signed [MW-1:0] dn_d [3];
  logic signed [MW-1:0] df_d [3];
  logic signed [MW-1:0] dn_q [3];
  logic signed [MW-1:0] df_q [3];
  logic signed [CW-1:0] dir_q [3];
  rasi_pkg::axis_flags_t fl_d [3];
  rasi_pkg::axis_flags_t fl0_q [3];
  rasi_pkg::axis_flags_t fl1_q [3];

  assign in_xfer = start && !busy;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (dir[a][CW-1]) begin
        dn_d[a] = {box_max_q[a][CW-1], box_max_q[a]} - {org[a][CW-1], org[a]};
        df_d[a] = {box_min_q[a][CW-1], box_min_q[a]} - {org[a][CW-1], org[a]};
      end else begin
        dn_d[a] = {box_min_q[a][CW-1], box_min_q[a]} - {org[a][CW-1], org[a]};
        df_d[a] = {box_max_q[a][CW-1], box_max_q[a]} - {org[a][CW-1], org[a]};
      end
      fl_d[a].dzero   = (dir[a] == '0);
      fl_d[a].in_slab = (org[a] >= box_min_q[a]) && (org[a] <= box_max_q[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      dn_q[a]  <= dn_d[a];
      df_q[a]  <= df_d[a];
      dir_q[a] <= dir[a];
      fl0_q[a] <= fl_d[a];
    end
  end

  // stage 1: magnitudes and quotient signs
  logic [MW-1:0] magn_q [3];
  logic [MW-1:0] magf_q [3];
  logic [CW-1:0] dm_q [3];
  logic          negn_q [3];
  logic          negf_q [3];

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      magn_q[a] <= dn_q[a][MW-1] ? MW'(-dn_q[a]) : MW'(dn_q[a]);
      magf_q[a] <= df_q[a][MW-1] ? MW'(-df_q[a]) : MW'(df_q[a]);
      negn_q[a] <= dn_q[a][MW-1] ^ dir_q[a][CW-1];
      negf_q[a] <= df_q[a][MW-1] ^ dir_q[a][CW-1];
      dm_q[a]   <= dir_q[a][CW-1] ? CW'(-dir_q[a]) : CW'(dir_q[a]);
      fl1_q[a]  <= fl0_q[a];
    end
  end

  // dividers
  logic signed [CW-1:0] an [3];
  logic signed [CW-1:0] af [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rasi_div u_div_near (
      .clk_i  (clk_i),
      .mag_i  (magn_q[a]),
      .dvs_i  (dm_q[a]),
      .neg_i  (negn_q[a]),
      .quot_o (an[a])
    );
    rasi_div u_div_far (
      .clk_i  (clk_i),
      .mag_i  (magf_q[a]),
      .dvs_i  (dm_q[a]),
      .neg_i  (negf_q[a]),
      .quot_o (af[a])
    );
  end

  // side flags ride alongside the dividers
  logic                  vd_q [DL];
  rasi_pkg::axis_flags_t sd_q [DL][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      for (int i = 0; i < DL; i++) vd_q[i] <= 1'b0;
    end else begin
      v0_q    <= in_xfer;
      v1_q    <= v0_q;
      vd_q[0] <= v1_q;
      for (int i = 1; i < DL; i++) vd_q[i] <= vd_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sd_q[0] <= fl1_q;
    for (int i = 1; i < DL; i++) sd_q[i] <= sd_q[i-1];
  end

  // merge x and y, then z
  rasi_pkg::slab_t m0, m1_d, m1_q, m2;
  logic signed [CW-1:0] anz_q, afz_q;
  rasi_pkg::axis_flags_t flz_q;
  logic vm_q;

  always_comb begin
    m0       = '0;
    m1_d     = rasi_pkg::slab_merge(m0, an[0], af[0], sd_q[DL-1][0]);
    m1_d     = rasi_pkg::slab_merge(m1_d, an[1], af[1], sd_q[DL-1][1]);
  end

  always_ff @(posedge clk_i) begin
    m1_q  <= m1_d;
    anz_q <= an[2];
    afz_q <= af[2];
    flz_q <= sd_q[DL-1][2];
  end

  always_comb begin
    m2 = rasi_pkg::slab_merge(m1_q, anz_q, afz_q, flz_q);
  end

  logic hit_d;
  assign hit_d = m2.have && !m2.fail && !m2.tmin[CW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      vm_q    <= vd_q[DL-1];
      valid_o <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_o      <= hit_d;
    fraction_o <= hit_d ? m2.tmin[CW-2:0] : '0;
  end

  `RASI_ASSERT(a_latency, clk_i, rst_ni, in_xfer |-> ##(rasi_pkg::PIPE_LAT) valid_o)
  `RASI_ASSERT(a_miss_zero, clk_i, rst_ni, (valid_o && !hit_o) |-> (fraction_o == '0))
  `RASI_ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, !vm_q, !valid_o)

endmodule

// ===== rtl/rasi_div.sv =====
// ---------------------------------------------------------------------------
// rasi_div
// Pipelined saturating divider: (mag << FRAC_W) / dvs, one quotient bit a stage.
// ---------------------------------------------------------------------------
module rasi_div (
  input  logic                                 clk_i,
  input  logic [rasi_pkg::MAG_W-1:0]           mag_i,
  input  logic [rasi_pkg::COORD_W-1:0]         dvs_i,
  input  logic                                 neg_i,
  output logic signed [rasi_pkg::COORD_W-1:0]  quot_o
);

  localparam int CW = rasi_pkg::COORD_W;
  localparam int QW = rasi_pkg::Q_W;
  localparam int NS = rasi_pkg::DIV_STEPS;

  logic [CW-1:0] rem_q [NS+1];
  logic [QW-1:0] quo_q [NS+1];
  logic [QW-1:0] low_q [NS+1];
  logic [CW-1:0] dvs_q [NS+1];
  logic          sat_q [NS+1];
  logic          neg_q [NS+1];

  logic [rasi_pkg::NUM_W-1:0] num;
  logic                       sat_d;

  always_comb begin
    num   = {mag_i, {rasi_pkg::FRAC_W{1'b0}}};
    // quotient reaches 2^QW exactly when mag >= dvs << (QW - FRAC_W)
    sat_d = ({{(CW + QW - rasi_pkg::NUM_W){1'b0}}, num} >= {dvs_i, {QW{1'b0}}});
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= CW'(num[rasi_pkg::NUM_W-1:QW]);
    low_q[0] <= num[QW-1:0];
    quo_q[0] <= '0;
    dvs_q[0] <= dvs_i;
    sat_q[0] <= sat_d;
    neg_q[0] <= neg_i;
  end

  for (genvar j = 0; j < NS; j++) begin : g_step
    logic [CW:0]   trial;
    logic          ge;
    logic [CW-1:0] rem_d;

    always_comb begin
      trial = {rem_q[j], low_q[j][QW-1-j]};
      ge    = (trial >= {1'b0, dvs_q[j]});
      rem_d = ge ? CW'(trial - {1'b0, dvs_q[j]}) : CW'(trial);
    end

    always_ff @(posedge clk_i) begin
      rem_q[j+1] <= rem_d;
      quo_q[j+1] <= {quo_q[j][QW-2:0], ge};
      low_q[j+1] <= low_q[j];
      dvs_q[j+1] <= dvs_q[j];
      sat_q[j+1] <= sat_q[j];
      neg_q[j+1] <= neg_q[j];
    end
  end

  logic [CW-1:0] qv;
  logic [CW-1:0] quot_d;

  always_comb begin
    qv = sat_q[NS] ? {1'b1, {QW{1'b0}}} : {1'b0, quo_q[NS]};
    if (neg_q[NS]) quot_d = CW'(-qv);
    else if (sat_q[NS]) quot_d = {1'b0, {QW{1'b1}}};
    else quot_d = qv;
  end

  always_ff @(posedge clk_i) begin
    quot_o <= quot_d;
  end

endmodule

// ===== dv/ray_aabb_slab_intersect_unit_tb.sv =====
// ---------------------------------------------------------------------------
// ray_aabb_slab_intersect_unit_tb
// Streams rays through the slab test unit under several box settings and
// sender idle rates, and checks every result against a local slab predictor.
// ---------------------------------------------------------------------------
module ray_aabb_slab_intersect_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  ONE        = 1 << rasi_pkg::FRAC_W;
  localparam int  IDLE_LIMIT = 4000;
  localparam int  RAND_RAYS  = 200;

  typedef logic signed [rasi_pkg::COORD_W-1:0] coord_t;

  typedef struct {
    coord_t org [3];
    coord_t dir [3];
  } ray_t;

  typedef struct {
    logic                         hit;
    logic [rasi_pkg::COORD_W-2:0] fraction;
  } hit_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [rasi_pkg::IDX_W-1:0]   cfg_index_i = '0;
  logic [rasi_pkg::COORD_W-1:0] cfg_data_i = '0;
  logic                         start = 1'b0;
  logic                         busy;
  coord_t             origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  coord_t             dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic                         valid_o;
  logic                         hit_o;
  logic [rasi_pkg::COORD_W-2:0] fraction_o;

  ray_aabb_slab_intersect_unit dut (.*);

  always #6 clk_i = ~clk_i;

  ray_t   pending_rays [$];
  hit_t   expected_hits [$];
  coord_t box [6] = '{default: '0};
  int     send_idle_pct = 0;
  int     error_count = 0;
  int     quiet_cycles = 0;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("%0t: mismatch: %s", $realtime, what);
  endtask

  // Saturated ((num - sub) << FRAC_W) / den, truncated toward zero
  function automatic coord_t slab_quot(longint num, longint sub, longint den);
    logic [63:0] mag, dm, q, r, lim;
    bit neg;
    lim = 64'h1 << (rasi_pkg::COORD_W - 1);
    neg = num < sub;
    mag = neg ? sub - num : num - sub;
    if (den < 0) begin
      dm = -den;
      neg = !neg;
    end else begin
      dm = den;
    end
    q = mag / dm;
    r = mag % dm;
    for (int i = 0; i < rasi_pkg::FRAC_W; i++) begin
      if (q < lim) begin
        r = r << 1;
        q = q << 1;
        if (r >= dm) begin
          r = r - dm;
          q[0] = 1'b1;
        end
      end
    end
    if (q > lim) q = lim;
    if (neg) return coord_t'(-q);
    if (q >= lim) q = lim - 1;
    return coord_t'(q);
  endfunction

  function automatic hit_t slab_hit(ray_t ray);
    hit_t   res;
    bit     have;
    longint tmin, tmax, lo, hi, org, dir, an, af;
    res = '{1'b0, '0};
    have = 0;
    tmin = 0;
    tmax = 0;
    for (int a = 0; a < 3; a++) begin
      lo = box[a];
      hi = box[a+3];
      org = ray.org[a];
      dir = ray.dir[a];
      if (dir == 0) begin
        if (org < lo || org > hi) return res;
        continue;
      end
      an = slab_quot(dir < 0 ? hi : lo, org, dir);
      af = slab_quot(dir < 0 ? lo : hi, org, dir);
      if (!have) begin
        tmin = an;
        tmax = af;
        have = 1;
        continue;
      end
      if (tmin > af || an > tmax) return res;
      if (an > tmin) tmin = an;
      if (af < tmax) tmax = af;
    end
    if (!have || tmin < 0) return res;
    res.hit = 1'b1;
    res.fraction = tmin[rasi_pkg::COORD_W-2:0];
    return res;
  endfunction

  // Box shadow follows each register transfer
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o && cfg_index_i < 6)
      box[cfg_index_i] <= cfg_data_i;
  end

  // Ray driver; the expectation is formed at the transfer edge
  always @(posedge clk_i or negedge rst_ni) begin
    ray_t r;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_hits.push_back(slab_hit('{
          '{origin_x_i, origin_y_i, origin_z_i}, '{dir_x_i, dir_y_i, dir_z_i}}));
      if (!start || !busy) begin
        if (pending_rays.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          r = pending_rays.pop_front();
          origin_x_i <= r.org[0];
          origin_y_i <= r.org[1];
          origin_z_i <= r.org[2];
          dir_x_i <= r.dir[0];
          dir_y_i <= r.dir[1];
          dir_z_i <= r.dir[2];
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    hit_t e;
    if (rst_ni && valid_o) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        e = expected_hits.pop_front();
        if (hit_o !== e.hit)
          report_mismatch($sformatf("hit %b, expected %b", hit_o, e.hit));
        if (fraction_o !== e.fraction)
          report_mismatch($sformatf("fraction %h, expected %h", fraction_o, e.fraction));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || valid_o || (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("ray_aabb_slab_intersect_unit_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic write_box(input coord_t lo_x, lo_y, lo_z, hi_x, hi_y, hi_z);
    coord_t v [6];
    logic [rasi_pkg::IDX_W-1:0] idx [6];
    v = '{lo_x, lo_y, lo_z, hi_x, hi_y, hi_z};
    idx = '{rasi_pkg::REG_MIN_X, rasi_pkg::REG_MIN_Y, rasi_pkg::REG_MIN_Z,
            rasi_pkg::REG_MAX_X, rasi_pkg::REG_MAX_Y, rasi_pkg::REG_MAX_Z};
    for (int i = 0; i < 6; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i <= v[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain;
    do @(posedge clk_i);
    while (pending_rays.size() > 0 || start || expected_hits.size() > 0);
    repeat (rasi_pkg::PIPE_LAT + 4) @(posedge clk_i);
  endtask

  task automatic add_ray(input coord_t ox, oy, oz, dx, dy, dz);
    pending_rays.push_back('{'{ox, oy, oz}, '{dx, dy, dz}});
  endtask

  // Mostly rays aimed near the box centre, some entirely random
  task automatic add_random_rays(input int n);
    ray_t   r;
    longint c, o, t;
    int     sh;
    repeat (n) begin
      sh = $urandom_range(8);
      for (int a = 0; a < 3; a++) begin
        if ($urandom_range(9) < 3) begin
          r.org[a] = $urandom;
          r.dir[a] = $urandom;
        end else begin
          c = (longint'(box[a]) + longint'(box[a+3])) / 2;
          o = c + $signed($urandom_range(1 << 23)) - (1 << 22);
          t = c + $signed($urandom_range(1 << 16)) - (1 << 15);
          r.org[a] = coord_t'(o);
          r.dir[a] = coord_t'((t - o) >>> sh);
        end
        if ($urandom_range(11) == 0) r.dir[a] = '0;
      end
      pending_rays.push_back(r);
    end
  endtask

  initial begin
    coord_t b, big, sml;
    b = 4 * ONE;
    big = 32'sh7fff_ffff;
    sml = 32'sh8000_0000;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // box at its reset value: a single point at the origin
    add_ray(-ONE, 0, 0, ONE, 0, 0);
    add_ray(0, 0, 0, 0, 0, 0);
    add_random_rays(20);
    drain();

    write_box(-b, -b, -b, b, b, b);
    add_ray(-2*b, 0, 0, ONE, 0, 0);
    add_ray(2*b, 0, 0, -ONE, 0, 0);
    add_ray(0, 0, 0, ONE, ONE, ONE);          // inside: entry behind origin
    add_ray(0, 0, 0, 0, 0, 0);                // no direction at all
    add_ray(b, -2*b, 0, 0, ONE, 0);           // zero dir, on the boundary
    add_ray(b + 1, -2*b, 0, 0, ONE, 0);       // zero dir, just outside
    add_ray(0, 0, -b - 1, ONE, ONE, 0);       // zero dir z, below min
    add_ray(big, big, big, sml, sml, sml);
    add_ray(sml, sml, sml, big, big, big);
    add_ray(sml, 0, 0, 1, 0, 0);              // quotient saturates high
    add_ray(big, 0, 0, -1, 0, 0);
    add_ray(-2*b, 2*b, 0, ONE, ONE, 0);       // disjoint slab intervals
    add_ray(-2*b, 0, 0, -ONE, 0, 0);          // pointing away
    add_ray(-2*b, -2*b, -2*b, 3, 7, -1);
    add_ray(-big, 17, -5, ONE/3, -1, 1);
    add_random_rays(RAND_RAYS);
    drain();

    send_idle_pct = 79;
    write_box(sml, sml, sml, big, big, big);
    add_random_rays(RAND_RAYS);
    drain();

    send_idle_pct = 12;
    write_box(b, ONE, 3*b, -b, -ONE, b);      // inverted on all three axes
    add_random_rays(RAND_RAYS);
    drain();

    send_idle_pct = 0;
    write_box($urandom_range(1 << 24) - (1 << 25), -$urandom_range(1 << 22), -ONE,
              $urandom_range(1 << 24), $urandom_range(1 << 22), 20 * ONE);
    add_random_rays(RAND_RAYS / 2);
    drain();
    send_idle_pct = 79;
    add_random_rays(RAND_RAYS / 2);
    drain();

    write_box(0, 0, 0, 0, 0, 0);
    send_idle_pct = 12;
    add_random_rays(RAND_RAYS / 2);
    drain();

    if (error_count == 0) $display("ray_aabb_slab_intersect_unit_tb: done, clean");
    else $display("ray_aabb_slab_intersect_unit_tb: done, errors");
    $finish;
  end

endmodule

// ===== ray_aabb_slab_intersect_unit.f =====
+incdir+rtl
rtl/rasi_pkg.sv
rtl/rasi_div.sv
rtl/ray_aabb_slab_intersect_unit.sv
dv/ray_aabb_slab_intersect_unit_tb.sv
